// File: src/sclp_pkg.sv
package sclp_pkg;

  localparam int unsigned LINE_LIMIT_DEF = 63;

  localparam logic [31:0] DEFAULT_COUNT = 32'd20;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [2:0] {
    CMD_HELP    = 3'd0,
    CMD_READ    = 3'd1,
    CMD_DUMP    = 3'd2,
    CMD_STAT    = 3'd3,
    CMD_UNKNOWN = 3'd4
  } cmd_e;

  localparam logic [7:0] KEYWORDS [4][4] = '{
    '{8'h68, 8'h65, 8'h6c, 8'h70},
    '{8'h72, 8'h65, 8'h61, 8'h64},
    '{8'h64, 8'h75, 8'h6d, 8'h70},
    '{8'h73, 8'h74, 8'h61, 8'h74}
  };

  typedef struct packed {
    logic [2:0]  command;
    logic        has_argument;
    logic [31:0] dump_count;
    logic        count_invalid;
    logic [31:0] dropped_lines;
  } result_t;

endpackage

// File: src/sclp_rx_if.sv
interface sclp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: src/sclp_res_if.sv
interface sclp_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic        has_argument;
  logic [31:0] dump_count;
  logic        count_invalid;
  logic [31:0] dropped_lines;

  modport source (
    output valid, output command, output has_argument, output dump_count,
    output count_invalid, output dropped_lines, input ready
  );
  modport sink (
    input valid, input command, input has_argument, input dump_count,
    input count_invalid, input dropped_lines, output ready
  );
endinterface

// File: src/serial_command_line_parser.sv
// Channel  | Dir | Payload                                          | Transaction
// rx_i     | in  | rx_byte                                          | one received byte
// res_o    | out | command, has_argument, dump_count, count_invalid, | one parsed line
//          |     | dropped_lines                                    |
//
// One byte per cycle while the output buffer is not full; each byte is registered,
// then updates the line state, and the result of a CR or LF is registered in the output buffer.
// The dump argument update (times ten plus digit, overflow check) sets the path.
// Reset clears all line state and the dropped line count; no clearing pass.
// A two-entry output buffer keeps input flowing through a stalled sink;
// input stalls only while both entries hold results.
module serial_command_line_parser #(
  parameter int unsigned LINE_LIMIT = sclp_pkg::LINE_LIMIT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sclp_rx_if.sink           rx_i,
  sclp_res_if.source        res_o
);

  localparam int unsigned LenW = $clog2(LINE_LIMIT + 1);

  logic [7:0]         rx_q;
  logic               rx_valid_q;
  logic               advance;

  logic [LenW-1:0]    len_q, len_d;
  logic               disc_q, disc_d;
  logic [1:0]         tok_q, tok_d;
  logic               inside_q, inside_d;
  logic [2:0]         pos_q, pos_d;
  logic [3:0]         cand_q, cand_d;
  logic [31:0]        val_q, val_d;
  logic               bad_q, bad_d;
  logic [31:0]        total_q, total_d;
  logic               ended_q, ended_d;

  logic               produce;
  sclp_pkg::result_t  res_new;
  sclp_pkg::result_t  out_q, skid_q;
  logic               out_valid_q, skid_valid_q;
  logic               out_free;

  sclp_pkg::cmd_e     cmd;
  logic               has_arg;
  logic               is_eol;
  logic               is_blank;
  logic               is_digit;
  logic [3:0]         digit;
  logic [35:0]        val_ext;
  logic [35:0]        val_next;

  assign advance     = rx_valid_q && !skid_valid_q;
  assign rx_i.ready  = !rx_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      rx_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      rx_q <= rx_i.rx_byte;
    end
  end

  always_comb begin
    cmd = sclp_pkg::CMD_UNKNOWN;
    if (pos_q == 3'd4) begin
      if (cand_q[0]) begin
        cmd = sclp_pkg::CMD_HELP;
      end else if (cand_q[1]) begin
        cmd = sclp_pkg::CMD_READ;
      end else if (cand_q[2]) begin
        cmd = sclp_pkg::CMD_DUMP;
      end else if (cand_q[3]) begin
        cmd = sclp_pkg::CMD_STAT;
      end
    end
    has_arg = (tok_q >= 2'd2);
    res_new.command       = cmd;
    res_new.has_argument  = has_arg;
    res_new.dump_count    = '0;
    res_new.count_invalid = 1'b0;
    res_new.dropped_lines = total_q;
    if (cmd == sclp_pkg::CMD_DUMP) begin
      if (!has_arg) begin
        res_new.dump_count = sclp_pkg::DEFAULT_COUNT;
      end else if (bad_q || val_q == '0) begin
        res_new.count_invalid = 1'b1;
      end else begin
        res_new.dump_count = val_q;
      end
    end
  end

  assign is_eol   = (rx_q == sclp_pkg::CHAR_CR) || (rx_q == sclp_pkg::CHAR_LF);
  assign is_blank = (rx_q == sclp_pkg::CHAR_SPACE) || (rx_q == sclp_pkg::CHAR_TAB);
  assign is_digit = (rx_q >= sclp_pkg::CHAR_ZERO) && (rx_q <= sclp_pkg::CHAR_NINE);
  assign digit    = 4'(rx_q - sclp_pkg::CHAR_ZERO);
  assign val_ext  = {4'b0, val_q};
  assign val_next = (val_ext << 3) + (val_ext << 1) + {32'b0, digit};

  always_comb begin
    len_d    = len_q;
    disc_d   = disc_q;
    tok_d    = tok_q;
    inside_d = inside_q;
    pos_d    = pos_q;
    cand_d   = cand_q;
    val_d    = val_q;
    bad_d    = bad_q;
    total_d  = total_q;
    ended_d  = ended_q;
    produce  = 1'b0;
    if (advance) begin
      if (is_eol || (!disc_q && len_q >= LenW'(LINE_LIMIT))) begin
        // end of line or overlong line: clear; an overlong line is then discarded up to its end
        produce  = is_eol && !disc_q && (len_q != '0) && (tok_q != 2'd0);
        len_d    = '0;
        disc_d   = !is_eol;
        tok_d    = '0;
        inside_d = 1'b0;
        pos_d    = '0;
        cand_d   = 4'hf;
        val_d    = '0;
        bad_d    = 1'b0;
        ended_d  = 1'b0;
        if (!is_eol) begin
          total_d = total_q + 32'd1;
        end
      end else if (!disc_q) begin
        len_d = LenW'(len_q + 1'b1);
        if (!ended_q) begin
          if (rx_q == sclp_pkg::CHAR_NUL) begin
            ended_d  = 1'b1;
            inside_d = 1'b0;
          end else if (is_blank) begin
            inside_d = 1'b0;
          end else begin
            inside_d = 1'b1;
            if (!inside_q) begin
              tok_d = (tok_q < 2'd2) ? 2'(tok_q + 2'd1) : 2'd3;
            end
            if (tok_d == 2'd1) begin
              if (pos_q < 3'd4) begin
                for (int k = 0; k < 4; k++) begin
                  if (sclp_pkg::KEYWORDS[k][pos_q[1:0]] != rx_q) begin
                    cand_d[k] = 1'b0;
                  end
                end
              end else begin
                cand_d = '0;
              end
              if (pos_q < 3'd5) begin
                pos_d = 3'(pos_q + 3'd1);
              end
            end else if (tok_d == 2'd2 && !bad_q) begin
              if (!is_digit || val_next[35:32] != 4'd0) begin
                bad_d = 1'b1;
              end else begin
                val_d = val_next[31:0];
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      disc_q   <= 1'b0;
      tok_q    <= '0;
      inside_q <= 1'b0;
      pos_q    <= '0;
      cand_q   <= 4'hf;
      val_q    <= '0;
      bad_q    <= 1'b0;
      total_q  <= '0;
      ended_q  <= 1'b0;
    end else begin
      len_q    <= len_d;
      disc_q   <= disc_d;
      tok_q    <= tok_d;
      inside_q <= inside_d;
      pos_q    <= pos_d;
      cand_q   <= cand_d;
      val_q    <= val_d;
      bad_q    <= bad_d;
      total_q  <= total_d;
      ended_q  <= ended_d;
    end
  end

  assign out_free = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || produce;
      skid_valid_q <= 1'b0;
    end else if (produce) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_new;
    end else if (produce) begin
      skid_q <= res_new;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.command       = out_q.command;
  assign res_o.has_argument  = out_q.has_argument;
  assign res_o.dump_count    = out_q.dump_count;
  assign res_o.count_invalid = out_q.count_invalid;
  assign res_o.dropped_lines = out_q.dropped_lines;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without output entry");

  a_cand_cleared_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q > 3'd4) |-> (cand_q == 4'h0))
    else $error("keyword candidates left on overlong first token");

  a_inside_has_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inside_q |-> (tok_q != 2'd0))
    else $error("inside a token with no token counted");

  a_invalid_only_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.count_invalid) |->
      (out_q.command == sclp_pkg::CMD_DUMP && out_q.has_argument))
    else $error("count_invalid on a non-dump result");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (total_q == $past(total_q) || total_q == $past(total_q) + 32'd1))
    else $error("dropped line count jumped");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned LINE_LIMIT = sclp_pkg::LINE_LIMIT_DEF;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned TOTAL_BYTES = 1450;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  sclp_rx_if  rx_if ();
  sclp_res_if res_if ();

  serial_command_line_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  string kw_names [4] = '{"help", "read", "dump", "stat"};

  logic [7:0]        tx_bytes [$];
  sclp_pkg::result_t line_results [$];

  int unsigned kept_len;
  bit          discarding;
  logic [1:0]  tok_count;
  bit          in_token;
  logic [2:0]  kw_pos;
  logic [3:0]  kw_alive;
  logic [31:0] arg_value;
  bit          arg_bad;
  logic [31:0] dropped_total;
  bit          nul_seen;

  int unsigned bytes_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned cmd_hits [5];
  int unsigned idle_cycles = 0;
  bit          timed_out = 1'b0;

  task automatic line_clear();
    kept_len   = 0;
    discarding = 1'b0;
    tok_count  = 2'd0;
    in_token   = 1'b0;
    kw_pos     = 3'd0;
    kw_alive   = 4'hf;
    arg_value  = 32'd0;
    arg_bad    = 1'b0;
    nul_seen   = 1'b0;
  endtask

  task automatic scan_char(input logic [7:0] c);
    logic [63:0] wide;
    if (nul_seen) return;
    if (c == sclp_pkg::CHAR_NUL) begin
      nul_seen = 1'b1;
      in_token = 1'b0;
      return;
    end
    if (c == sclp_pkg::CHAR_SPACE || c == sclp_pkg::CHAR_TAB) begin
      in_token = 1'b0;
      return;
    end
    if (!in_token) begin
      in_token  = 1'b1;
      tok_count = (tok_count < 2'd2) ? tok_count + 2'd1 : 2'd3;
    end
    if (tok_count == 2'd1) begin
      if (kw_pos < 3'd4) begin
        for (int k = 0; k < 4; k++) begin
          if (kw_names[k][kw_pos] != c) kw_alive[k] = 1'b0;
        end
      end else begin
        kw_alive = 4'h0;
      end
      if (kw_pos < 3'd5) kw_pos = kw_pos + 3'd1;
    end else if (tok_count == 2'd2 && !arg_bad) begin
      if (c < sclp_pkg::CHAR_ZERO || c > sclp_pkg::CHAR_NINE) begin
        arg_bad = 1'b1;
      end else begin
        wide = {32'd0, arg_value} * 64'd10 + {56'd0, c - sclp_pkg::CHAR_ZERO};
        if (wide > 64'h0000_0000_ffff_ffff) arg_bad = 1'b1;
        else arg_value = wide[31:0];
      end
    end
  endtask

  task automatic parse_rx_byte(input logic [7:0] c, output bit produced,
                               output sclp_pkg::result_t res);
    sclp_pkg::cmd_e cmd;
    produced = 1'b0;
    res      = '0;
    if (c == sclp_pkg::CHAR_CR || c == sclp_pkg::CHAR_LF) begin
      if (!discarding && kept_len > 0 && tok_count != 2'd0) begin
        cmd = sclp_pkg::CMD_UNKNOWN;
        if (kw_pos == 3'd4) begin
          for (int k = 3; k >= 0; k--) begin
            if (kw_alive[k]) cmd = sclp_pkg::cmd_e'(k);
          end
        end
        res.command       = cmd;
        res.has_argument  = (tok_count >= 2'd2);
        res.dropped_lines = dropped_total;
        if (cmd == sclp_pkg::CMD_DUMP) begin
          if (!res.has_argument) res.dump_count = sclp_pkg::DEFAULT_COUNT;
          else if (arg_bad || arg_value == 32'd0) res.count_invalid = 1'b1;
          else res.dump_count = arg_value;
        end
        produced = 1'b1;
      end
      line_clear();
      return;
    end
    if (discarding) return;
    if (kept_len < LINE_LIMIT) begin
      kept_len++;
      scan_char(c);
    end else begin
      line_clear();
      discarding    = 1'b1;
      dropped_total = dropped_total + 32'd1;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
  endtask

  task automatic push_seps(input int unsigned lo, input int unsigned hi);
    int unsigned n;
    n = $urandom_range(lo, hi);
    repeat (n) begin
      tx_bytes.push_back($urandom_range(0, 1) ? sclp_pkg::CHAR_SPACE : sclp_pkg::CHAR_TAB);
    end
  endtask

  task automatic push_end();
    case ($urandom_range(0, 2))
      0: tx_bytes.push_back(sclp_pkg::CHAR_CR);
      1: tx_bytes.push_back(sclp_pkg::CHAR_LF);
      default: push_text("\r\n");
    endcase
  endtask

  function automatic logic [7:0] rand_letter();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  task automatic push_first_token();
    int unsigned r;
    int unsigned k;
    string s;
    r = $urandom_range(0, 99);
    k = ($urandom_range(0, 99) < 40) ? 2 : $urandom_range(0, 3);
    s = kw_names[k];
    if (r < 70) begin
      push_text(s);
    end else if (r < 78) begin
      push_text(s.substr(0, $urandom_range(0, 2)));
    end else if (r < 86) begin
      push_text(s);
      tx_bytes.push_back(rand_letter());
    end else if (r < 94) begin
      s.putc($urandom_range(0, 3), rand_letter());
      push_text(s);
    end else begin
      repeat ($urandom_range(1, 6)) tx_bytes.push_back(rand_letter());
    end
  endtask

  task automatic push_number();
    string s;
    case ($urandom_range(0, 9))
      0: s = "0";
      1: s = "000";
      2: s = $sformatf("%0d", 64'd4294967295 - 64'($urandom_range(0, 3)));
      3: s = $sformatf("%0d", 64'd4294967296 + 64'($urandom_range(0, 3)));
      4: s = $sformatf("%0d", $urandom());
      5: s = $sformatf("%0d%0d", $urandom(), $urandom_range(0, 999));
      6: begin
        s = $sformatf("%0d", $urandom_range(0, 99));
        if ($urandom_range(0, 1)) s = {"x", s};
        else s = {s, ":"};
      end
      7: s = $sformatf("00%0d", $urandom_range(1, 99999));
      default: s = $sformatf("%0d", $urandom_range(1, 999));
    endcase
    push_text(s);
  endtask

  task automatic add_random_line();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 12)) tx_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 12) begin
      if ($urandom_range(0, 1)) push_text("dump 5 ");
      repeat ($urandom_range(58, 100)) begin
        tx_bytes.push_back($urandom_range(0, 4) == 0 ? sclp_pkg::CHAR_SPACE : rand_letter());
      end
    end else if (kind < 14) begin
      push_seps(0, 3);
    end else begin
      push_seps(0, 2);
      push_first_token();
      if ($urandom_range(0, 99) < 60) begin
        push_seps(1, 3);
        push_number();
        if ($urandom_range(0, 99) < 15) begin
          push_seps(1, 2);
          push_text($urandom_range(0, 1) ? "extra" : "7");
        end
      end
      if ($urandom_range(0, 99) < 5) begin
        tx_bytes.push_back(sclp_pkg::CHAR_NUL);
        push_text("help 9");
      end
      push_seps(0, 2);
    end
    push_end();
  endtask

  task automatic add_directed_lines();
    string filler;
    push_text("help\n");
    push_text("read\r");
    push_text("dump\r\n");
    push_text("stat\n");
    push_text("dump 4294967295\n");
    push_text("dump 4294967296\n");
    push_text("dump 0\n");
    push_text("dump 12a\n");
    push_text(" \tdump\t 7  extra more\n");
    push_text("helpx\n");
    push_text("hel\n");
    push_text("read 5\n");
    push_text("\n\r  \t \r");
    filler = "";
    repeat (58) filler = {filler, " "};
    push_text({"stat", filler, "x\n"});
    filler = "";
    repeat (64) filler = {filler, "a"};
    push_text({filler, "\n"});
    push_text({"dump 3", filler, "\rhelp\n"});
    push_text("du");
    tx_bytes.push_back(sclp_pkg::CHAR_NUL);
    push_text("mp\n");
    tx_bytes.push_back(sclp_pkg::CHAR_NUL);
    push_text("help\n");
    tx_bytes.push_back(8'hff);
    push_text("\n");
  endtask

  int unsigned src_gap;
  int unsigned src_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    bit                produced;
    sclp_pkg::result_t res;
    if (!rst_ni) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= 8'h00;
      src_gap  = 0;
      src_calm = 0;
      dropped_total = 32'd0;
      line_clear();
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        bytes_sent++;
        parse_rx_byte(rx_if.rx_byte, produced, res);
        if (produced) begin
          line_results.push_back(res);
          cmd_hits[res.command]++;
        end
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          rx_if.valid <= 1'b0;
        end else if (tx_bytes.size() > 0) begin
          rx_if.valid   <= 1'b1;
          rx_if.rx_byte <= tx_bytes.pop_front();
          if (src_calm > 0) src_calm--;
          else if ($urandom_range(0, 99) < 2) src_calm = $urandom_range(20, 100);
          else src_gap = pick_gap();
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  int unsigned sink_stall;
  int unsigned sink_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    sclp_pkg::result_t got;
    sclp_pkg::result_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      sink_stall = 0;
      sink_calm  = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        got.command       = res_if.command;
        got.has_argument  = res_if.has_argument;
        got.dump_count    = res_if.dump_count;
        got.count_invalid = res_if.count_invalid;
        got.dropped_lines = res_if.dropped_lines;
        if (line_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: cmd=%0d arg=%0b cnt=%0d inv=%0b drop=%0d",
                     got.command, got.has_argument, got.dump_count, got.count_invalid,
                     got.dropped_lines);
          end
        end else begin
          want = line_results.pop_front();
          if (got.command !== want.command || got.has_argument !== want.has_argument ||
              got.dump_count !== want.dump_count || got.count_invalid !== want.count_invalid ||
              got.dropped_lines !== want.dropped_lines) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d mismatch: expected cmd=%0d arg=%0b cnt=%0d inv=%0b drop=%0d",
                       results_seen, want.command, want.has_argument, want.dump_count,
                       want.count_invalid, want.dropped_lines);
              $display("  actual cmd=%0d arg=%0b cnt=%0d inv=%0b drop=%0d",
                       got.command, got.has_argument, got.dump_count, got.count_invalid,
                       got.dropped_lines);
            end
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (sink_calm > 0) sink_calm--;
        else if ($urandom_range(0, 99) < 3) sink_calm = $urandom_range(20, 100);
        else if ($urandom_range(0, 99) < 25) sink_stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) timed_out <= 1'b1;
  end

  initial begin
    add_directed_lines();
    while (tx_bytes.size() < TOTAL_BYTES) add_random_line();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!timed_out && (tx_bytes.size() != 0 || rx_if.valid || line_results.size() != 0)) begin
      @(posedge clk_i);
    end

    if (timed_out) begin
      $display("timeout after %0d idle cycles, %0d results outstanding",
               IDLE_LIMIT, line_results.size());
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      if (line_results.size() != 0) begin
        $display("%0d expected results never arrived", line_results.size());
      end
    end
    $display("covered %0d bytes, %0d line results", bytes_sent, results_seen);
    $display("  help %0d read %0d dump %0d stat %0d unknown %0d, %0d dropped, %0d mismatches",
             cmd_hits[sclp_pkg::CMD_HELP], cmd_hits[sclp_pkg::CMD_READ],
             cmd_hits[sclp_pkg::CMD_DUMP], cmd_hits[sclp_pkg::CMD_STAT],
             cmd_hits[sclp_pkg::CMD_UNKNOWN], dropped_total, mismatches);
    if (!timed_out && mismatches == 0 && line_results.size() == 0) begin
      $display("serial_command_line_parser regression: pass");
    end else begin
      $display("serial_command_line_parser regression: fail");
    end
    $finish;
  end

endmodule
